// ===== sv/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants of the telnet command filter
// Telnet command codes, parser state and request codes, and the record that
// carries one parsed item from the parser to the output sequencer.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;

  // Beats produced by one received byte.
  localparam logic [1:0] BEATS_NONE  = 2'd0;
  localparam logic [1:0] BEATS_DATA  = 2'd1;
  localparam logic [1:0] BEATS_REPLY = 2'd3;

  localparam logic DEST_CONSOLE = 1'b0;
  localparam logic DEST_NET     = 1'b1;

  typedef enum logic [4:0] {
    ST_DATA    = 5'b00001,
    ST_CMD     = 5'b00010,
    ST_OPT     = 5'b00100,
    ST_SUB     = 5'b01000,
    ST_SUB_IAC = 5'b10000
  } tcf_state_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_DO    = 2'd1,
    REQ_WILL  = 2'd2,
    REQ_QUIET = 2'd3
  } tcf_req_e;

  // Parsed item: up to three beats, dest applies to all of them.
  typedef struct packed {
    logic [1:0] cnt;
    logic       dest;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } tcf_item_t;

endpackage

// ===== sv/tcf_parser.sv =====
// ----------------------------------------------------------------------------
// tcf_parser: telnet command parser
// Decodes one registered byte against the parser state and builds the beats
// it causes; the state advances when the byte is consumed.
// ----------------------------------------------------------------------------
module tcf_parser
  import tcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,   // byte consumed this cycle
  input  logic [7:0] byte_i,
  output tcf_item_t item_o
);

  tcf_state_e state_q, state_d;
  tcf_req_e   req_q, req_d;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    item_o.cnt  = BEATS_NONE;
    item_o.dest = DEST_CONSOLE;
    item_o.b0   = byte_i;
    item_o.b1   = TN_WONT;
    item_o.b2   = byte_i;
    case (state_q)
      ST_CMD: begin
        if (byte_i == TN_IAC) begin
          item_o.cnt = BEATS_DATA;    // doubled IAC -> literal 255
          state_d    = ST_DATA;
        end else if (byte_i == TN_SB) begin
          state_d = ST_SUB;
        end else if (byte_i == TN_DO) begin
          req_d   = REQ_DO;
          state_d = ST_OPT;
        end else if (byte_i == TN_WILL) begin
          req_d   = REQ_WILL;
          state_d = ST_OPT;
        end else if (byte_i == TN_DONT || byte_i == TN_WONT) begin
          req_d   = REQ_QUIET;
          state_d = ST_OPT;
        end else begin
          state_d = ST_DATA;
        end
      end
      ST_OPT: begin
        item_o.dest = DEST_NET;
        item_o.b0   = TN_IAC;
        item_o.b1   = (req_q == REQ_WILL) ? TN_DONT : TN_WONT;
        if (req_q == REQ_DO || req_q == REQ_WILL) begin
          item_o.cnt = BEATS_REPLY;
        end
        req_d   = REQ_NONE;
        state_d = ST_DATA;
      end
      ST_SUB: begin
        if (byte_i == TN_IAC) begin
          state_d = ST_SUB_IAC;
        end
      end
      ST_SUB_IAC: begin
        state_d = (byte_i == TN_SE) ? ST_DATA : ST_SUB;
      end
      default: begin
        if (byte_i == TN_IAC) begin
          state_d = ST_CMD;
        end else begin
          item_o.cnt = BEATS_DATA;
          state_d    = ST_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DATA;
      req_q   <= REQ_NONE;
    end else if (step_i) begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  // A pending request only lives while the option byte is awaited.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q != REQ_NONE) |-> (state_q == ST_OPT))
    else $error("tcf_parser: request pending outside option state");

  // Every option byte clears the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state_q == ST_OPT) |=> (req_q == REQ_NONE && state_q == ST_DATA))
    else $error("tcf_parser: option byte did not close the command");

  // State register stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("tcf_parser: state register not one-hot");

endmodule

// ===== sv/tcf_out_seq.sv =====
// ----------------------------------------------------------------------------
// tcf_out_seq: result register and beat sequencer
// Holds one parsed item and plays its beats out on the master stream; a new
// item may load while it is empty or in the cycle the last beat leaves.
// ----------------------------------------------------------------------------
module tcf_out_seq
  import tcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  tcf_item_t item_i,
  output logic      free_o,   // may load this cycle
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic      m_tuser_o,
  output logic      m_tlast_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       dest_q;
  logic [7:0] b0_q, b1_q, b2_q;
  logic       fire;

  assign m_tvalid_o = (cnt_q != BEATS_NONE);
  assign m_tlast_o  = (idx_q == cnt_q - 2'd1);
  assign m_tuser_o  = dest_q;
  assign fire       = m_tvalid_o && m_tready_i;
  assign free_o     = !m_tvalid_o || (fire && m_tlast_o);

  always_comb begin
    case (idx_q)
      2'd0:    m_tdata_o = b0_q;
      2'd1:    m_tdata_o = b1_q;
      default: m_tdata_o = b2_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (fire) begin
      if (m_tlast_o) begin
        cnt_d = BEATS_NONE;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      cnt_d = item_i.cnt;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= BEATS_NONE;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dest_q <= item_i.dest;
      b0_q   <= item_i.b0;
      b1_q   <= item_i.b1;
      b2_q   <= item_i.b2;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (idx_q < cnt_q))
    else $error("tcf_out_seq: beat index beyond item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == BEATS_NONE || cnt_q == BEATS_DATA || cnt_q == BEATS_REPLY))
    else $error("tcf_out_seq: illegal beat count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("tcf_out_seq: load over an unfinished item");

endmodule

// ===== sv/telnet_command_filter.sv =====
// ----------------------------------------------------------------------------
// telnet_command_filter: telnet receive-side command filter
// Strips telnet commands from the received byte stream, passes data bytes to
// the console side and refuses option requests on the network side.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one received network byte per request.
//   Master stream m_axis_*: tdata carries the emitted byte, tuser says where
//   it goes (0 console data, 1 reply to network), tlast marks the final beat
//   caused by one received byte.
//   A plain data byte or a doubled IAC gives one console beat. IAC DO opt
//   gives the reply IAC WONT opt, IAC WILL opt gives IAC DONT opt, each as
//   three network beats. Other commands and subnegotiations give nothing.
//   Path: an accepted byte passes the input register, then the result
//   register, before its first output beat.
//   Throughput: one byte per cycle while each byte yields at most one beat
//   and the receiver does not stall; a three-beat reply holds the result
//   register until its last beat leaves: the rate limit of the output sequencer.
//   Reset: parser returns to the data state, both registers empty.
//   Receiver stall: the result register holds its beat, the input register
//   takes one more byte, then s_axis_tready_o drops until room appears.
// ----------------------------------------------------------------------------
module telnet_command_filter
  import tcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_dest
  output logic       m_axis_tlast_o    // last
);

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;

  tcf_item_t  item;
  logic       seq_free;
  logic       step;     // registered byte moves through the parser
  logic       load;     // and produced at least one beat

  assign step            = in_vld_q && seq_free;
  assign load            = step && (item.cnt != BEATS_NONE);
  assign s_axis_tready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (step) begin
      in_vld_d = 1'b0;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  tcf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .item_o (item)
  );

  tcf_out_seq u_out_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .item_i     (item),
    .free_o     (seq_free),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the telnet command filter
// Sends received-byte requests into the slave stream and checks every beat of
// the master stream against an in-bench parser that tracks the telnet state
// (data, command, option, subnegotiation). Directed sequences come first, then
// random well-formed command sequences mixed with noise, under several
// sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import tcf_pkg::*;

  // Expected output beat, same fields as the master stream.
  typedef struct packed {
    logic [7:0] data;  // tdata
    logic       dest;  // tuser
    logic       last;  // tlast
  } beat_t;

  localparam int TAIL_CYCLES = 8;  // settle time after the last owed beat

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  // Parser mirror and the beats it still owes.
  tcf_state_e mirror_state = ST_DATA;
  tcf_req_e   mirror_req = REQ_NONE;
  beat_t      owed_beats_q[$];

  int src_idle_pct = 0;  // chance per request slot that the sender waits
  int snk_stall_pct = 0; // chance per cycle that the receiver holds off
  int bytes_sent = 0;
  int beats_checked = 0;
  int replies_seen = 0;
  int mismatches = 0;

  telnet_command_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),          // [7:0] rx_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] out_dest
    .m_axis_tlast_o  (m_axis_tlast_o)    // last
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser mirror: advance one received byte and queue the beats it causes.
  // --------------------------------------------------------------------------
  function automatic void queue_refusal(input logic [7:0] verb, input logic [7:0] opt);
    owed_beats_q.push_back('{data: TN_IAC, dest: DEST_NET, last: 1'b0});
    owed_beats_q.push_back('{data: verb, dest: DEST_NET, last: 1'b0});
    owed_beats_q.push_back('{data: opt, dest: DEST_NET, last: 1'b1});
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] c);
    case (mirror_state)
      ST_CMD: begin
        if (c == TN_IAC) begin
          // escaped 255 is data
          owed_beats_q.push_back('{data: TN_IAC, dest: DEST_CONSOLE, last: 1'b1});
          mirror_state = ST_DATA;
        end else if (c == TN_SB) begin
          mirror_state = ST_SUB;
        end else if (c == TN_DO) begin
          mirror_req = REQ_DO;
          mirror_state = ST_OPT;
        end else if (c == TN_WILL) begin
          mirror_req = REQ_WILL;
          mirror_state = ST_OPT;
        end else if (c == TN_DONT || c == TN_WONT) begin
          mirror_req = REQ_QUIET;
          mirror_state = ST_OPT;
        end else begin
          // any other command is dropped
          mirror_state = ST_DATA;
        end
      end
      ST_OPT: begin
        // option byte may be any value, 255 included
        if (mirror_req == REQ_DO) queue_refusal(TN_WONT, c);
        else if (mirror_req == REQ_WILL) queue_refusal(TN_DONT, c);
        mirror_req = REQ_NONE;
        mirror_state = ST_DATA;
      end
      ST_SUB: begin
        if (c == TN_IAC) mirror_state = ST_SUB_IAC;
      end
      ST_SUB_IAC: begin
        // only IAC SE closes; IAC plus anything else stays inside
        mirror_state = (c == TN_SE) ? ST_DATA : ST_SUB;
      end
      default: begin
        if (c == TN_IAC) begin
          mirror_state = ST_CMD;
        end else begin
          owed_beats_q.push_back('{data: c, dest: DEST_CONSOLE, last: 1'b1});
          mirror_state = ST_DATA;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one request per call. tvalid stays high between back-to-back
  // requests; it only drops while the sender idles or drain_results stops sending.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Stop sending until every owed beat came out, then let the pipe settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (owed_beats_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker: random tready, compare each accepted beat with the
  // oldest owed one. Values are sampled as they stood before the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (owed_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat data=%02h dest=%0b last=%0b", $realtime,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = owed_beats_q.pop_front();
        beats_checked++;
        if (m_axis_tuser_o == DEST_NET && m_axis_tlast_o) replies_seen++;
        if (m_axis_tdata_o !== want.data || m_axis_tuser_o !== want.dest ||
            m_axis_tlast_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: beat mismatch exp data=%02h dest=%0b last=%0b,",
                      " got data=%02h dest=%0b last=%0b"},
                     $realtime, want.data, want.dest, want.last,
                     m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes, each command kind and the subnegotiation corner cases.
  task automatic test_directed();
    send_byte(8'h00);                                   // lowest data byte
    send_byte(TN_IAC); send_byte(TN_IAC);               // escaped 255
    send_byte(TN_IAC); send_byte(TN_DO); send_byte(8'h00);    // refused, WONT
    send_byte(TN_IAC); send_byte(TN_WILL); send_byte(TN_IAC); // option 255, DONT
    send_byte(TN_IAC); send_byte(TN_DONT); send_byte(8'h18);  // swallowed
    send_byte(TN_IAC); send_byte(TN_WONT); send_byte(8'h01);  // swallowed
    send_byte(TN_IAC); send_byte(TN_SE);                // SE outside sub: other cmd
    // IAC IAC and IAC + plain byte stay inside; IAC SE ends it
    send_byte(TN_IAC); send_byte(TN_SB);
    send_byte(TN_IAC); send_byte(TN_IAC);
    send_byte(TN_IAC); send_byte(8'h01);
    send_byte(TN_IAC); send_byte(TN_SE);
    drain_results();
  endtask

  // Mostly well-formed command sequences with random content, plus noise and
  // unterminated subnegotiations.
  task automatic test_random_traffic(input int n_bytes);
    int first;
    int pick;
    int len;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_byte(8'($urandom_range(254)));
      end else if (pick < 42) begin
        send_byte(TN_IAC); send_byte(TN_IAC);
      end else if (pick < 62) begin
        send_byte(TN_IAC);
        send_byte($urandom_range(1) ? TN_DO : TN_WILL);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 70) begin
        send_byte(TN_IAC);
        send_byte($urandom_range(1) ? TN_DONT : TN_WONT);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 76) begin
        send_byte(TN_IAC); send_byte(8'($urandom_range(255)));
      end else if (pick < 90) begin
        send_byte(TN_IAC); send_byte(TN_SB);
        len = $urandom_range(6);
        repeat (len) send_byte(($urandom_range(3) == 0) ? TN_IAC : 8'($urandom_range(255)));
        // now and then leave it open so later bytes get swallowed
        if ($urandom_range(9) != 0) begin
          send_byte(TN_IAC); send_byte(TN_SE);
        end
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();

    // no idling on either side
    src_idle_pct = 0;  snk_stall_pct = 0;
    test_random_traffic(45);
    drain_results();
    // sender idle most of the time
    src_idle_pct = 59; snk_stall_pct = 0;
    test_random_traffic(45);
    drain_results();
    // receiver stalling most of the time; replies back up into the input
    src_idle_pct = 0;  snk_stall_pct = 59;
    test_random_traffic(45);
    drain_results();
    // light idling on both sides
    src_idle_pct = 6;  snk_stall_pct = 6;
    test_random_traffic(45);
    drain_results();

    $display("Sent %0d received bytes; checked %0d output beats, %0d of them refusal replies.",
             bytes_sent, beats_checked, replies_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && owed_beats_q.size() == 0) begin
      $display("** telnet_command_filter: PASSED **");
    end else begin
      $display("** telnet_command_filter: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d beats still owed", owed_beats_q.size());
    $display("** telnet_command_filter: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcf_pkg.sv
sv/tcf_parser.sv
sv/tcf_out_seq.sv
sv/telnet_command_filter.sv
verif/tb.sv
